FILE: rtl/core/block_cache_age_policy_macros.svh
// Assertion macros shared by the block cache age policy RTL.
`ifndef BLOCK_CACHE_AGE_POLICY_MACROS_SVH
`define BLOCK_CACHE_AGE_POLICY_MACROS_SVH

`ifndef ASSERT_OFF
// Assert a property, checked at every rising clock edge outside reset.
`define BCAP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert that a condition never holds outside reset.
`define BCAP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BCAP_ASSERT(lbl, clk, rstn, prop, msg)
`define BCAP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/core/bcap_pkg.sv
// Package with types and constants of the block cache age policy.
package bcap_pkg;

  localparam int unsigned WaysDefault      = 3;
  localparam int unsigned BlockBitsDefault = 24;
  localparam int unsigned AgeBitsDefault   = 16;
  localparam int unsigned WayOutBits       = 4;

  // Request kinds carried in the input tuser bit.
  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic last;
  } status_t;

endpackage

FILE: rtl/core/bcap_ctrl.sv
// Controller state machine of the block cache age policy.
`include "block_cache_age_policy_macros.svh"

module bcap_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  bcap_pkg::status_t status_i,
  output bcap_pkg::cmd_t    cmd_o
);
  import bcap_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   done;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_ready_i;
  assign done     = status_i.match || status_i.last;

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence one item: accept, scan the ways, emit on the terminating step.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!done) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.step = 1'b1;
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Track the output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;

  `BCAP_ASSERT(a_accept_scans, clk_i, rst_ni, (s_valid_i && s_ready_o) |=> (state_q == S_SCAN), "accepted item did not start a scan")
  `BCAP_ASSERT(a_result_from_scan, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == S_SCAN), "result appeared without a scan")
  `BCAP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.emit && out_valid_q && !m_ready_i, "pending result overwritten")

endmodule

FILE: rtl/core/bcap_dp.sv
// Datapath of the block cache age policy: tags, ages, scan pointer, result.
module bcap_dp #(
  parameter int unsigned WAYS       = bcap_pkg::WaysDefault,
  parameter int unsigned BLOCK_BITS = bcap_pkg::BlockBitsDefault,
  parameter int unsigned AGE_BITS   = bcap_pkg::AgeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcap_pkg::cmd_t                cmd_i,
  input  logic                          mode_i,
  input  logic [BLOCK_BITS-1:0]         block_number_i,
  output bcap_pkg::status_t             status_o,
  output logic                          hit_o,
  output logic [bcap_pkg::WayOutBits-1:0] way_o,
  output logic                          fill_o
);
  import bcap_pkg::*;

  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [BLOCK_BITS-1:0] tags_q [WAYS];
  logic [AGE_BITS-1:0]   ages_q [WAYS];
  logic [WayW-1:0]       ptr_q;
  logic [WayW-1:0]       cnt_q;
  logic [WayW-1:0]       victim_q;
  logic [AGE_BITS-1:0]   victim_age_q;
  logic                  mode_q;
  logic [BLOCK_BITS-1:0] tag_q;
  logic                  hit_q, fill_q;
  logic [WayW-1:0]       way_q;

  logic [WayW:0]         ptr_inc;
  logic [WayW-1:0]       ptr_next;
  logic [WayW-1:0]       idx;
  logic [AGE_BITS-1:0]   age_cur;
  logic [AGE_BITS-1:0]   aged;
  logic                  match;
  logic                  last;
  logic                  is_read;
  logic                  cand_wins;
  logic [WayW-1:0]       fin_victim;
  logic                  res_hit, res_fill;
  logic [WayW-1:0]       res_way;

  // Advance the rotating pointer with wrap at the way count.
  assign ptr_inc  = {1'b0, ptr_q} + (WayW+1)'(1);
  assign ptr_next = (ptr_inc >= (WayW+1)'(WAYS)) ? '0 : ptr_inc[WayW-1:0];

  // Select the way under test: rotating for reads, in order for writes.
  assign is_read = (mode_q == ModeRead);
  assign idx     = is_read ? ptr_next : cnt_q;
  assign age_cur = ages_q[idx];
  assign aged    = (age_cur == '1) ? age_cur : age_cur + AGE_BITS'(1);
  assign match   = (tags_q[idx] == tag_q);
  assign last    = (cnt_q == WayW'(WAYS - 1));

  assign cand_wins  = (victim_age_q < aged);
  assign fin_victim = cand_wins ? idx : victim_q;

  assign status_o.match = match;
  assign status_o.last  = last;

  // Form the result of the terminating step.
  always_comb begin
    res_hit  = 1'b0;
    res_fill = 1'b0;
    res_way  = '0;
    if (match) begin
      res_hit = 1'b1;
      res_way = idx;
    end else if (is_read) begin
      res_fill = 1'b1;
      res_way  = fin_victim;
    end
  end

  // Capture the request and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q       <= mode_i;
      tag_q        <= block_number_i;
      cnt_q        <= '0;
      victim_q     <= '0;
      victim_age_q <= ages_q[0];
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + WayW'(1);
      if (!match && cand_wins) begin
        victim_q     <= idx;
        victim_age_q <= aged;
      end
    end
  end

  // Update tags, ages and pointer on each step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int w = 0; w < WAYS; w++) begin
        tags_q[w] <= '0;
        ages_q[w] <= '0;
      end
    end else if (cmd_i.step) begin
      if (is_read) begin
        ptr_q <= ptr_next;
      end
      for (int w = 0; w < WAYS; w++) begin
        if (is_read && last && !match && (WayW'(w) == fin_victim)) begin
          ages_q[w] <= '0;
          tags_q[w] <= tag_q;
        end else if (WayW'(w) == idx) begin
          ages_q[w] <= match ? '0 : aged;
        end
      end
    end
  end

  // Hold the result for the output channel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hit_q  <= res_hit;
      fill_q <= res_fill;
      way_q  <= res_way;
    end
  end

  assign hit_o  = hit_q;
  assign fill_o = fill_q;
  assign way_o  = WayOutBits'(way_q);

endmodule

FILE: rtl/core/block_cache_age_policy.sv
// Top level of the block cache age policy: controller plus datapath.
//
//  channel  dir  tdata                 tuser             tlast
//  s_axis   in   block_number          mode (0 rd, 1 wr) -
//  m_axis   out  way                   hit, fill         -
//
// A request is accepted, then the ways are scanned one at a time
// through the shared compare and age unit; a hit ends the scan early.
// The next request is accepted as soon as the scan has finished, while its
// result may still wait in the output register.
// The terminating scan step stalls while an earlier result is not yet taken.
// Reset clears tags, ages, scan pointer and the output valid; the input side comes up ready.
module block_cache_age_policy #(
  parameter int unsigned WAYS       = bcap_pkg::WaysDefault,
  parameter int unsigned BLOCK_BITS = bcap_pkg::BlockBitsDefault,
  parameter int unsigned AGE_BITS   = bcap_pkg::AgeBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: block_number, zero padded to bytes
  input  logic [((BLOCK_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // tuser: mode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: way, zero padded to bytes
  output logic [7:0]                        m_axis_tdata,
  // tuser: hit (bit 0), fill (bit 1)
  output logic [1:0]                        m_axis_tuser
);
  import bcap_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic                    hit, fill;
  logic [WayOutBits-1:0]   way;

  bcap_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bcap_dp #(
    .WAYS       (WAYS),
    .BLOCK_BITS (BLOCK_BITS),
    .AGE_BITS   (AGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (s_axis_tuser),
    .block_number_i (s_axis_tdata[BLOCK_BITS-1:0]),
    .status_o       (status),
    .hit_o          (hit),
    .way_o          (way),
    .fill_o         (fill)
  );

  // Pack the result item.
  assign m_axis_tdata = {{(8 - WayOutBits){1'b0}}, way};
  assign m_axis_tuser = {fill, hit};

endmodule

FILE: sim/tb_block_cache_age_policy.sv
// Self-checking testbench for the block cache age policy: directed table and random requests.
`timescale 1ns / 1ps

module tb_block_cache_age_policy;
  import bcap_pkg::*;

  localparam int unsigned WAYS         = WaysDefault;
  localparam int unsigned BLOCK_BITS   = BlockBitsDefault;
  localparam int unsigned AGE_BITS     = AgeBitsDefault;
  localparam int unsigned TDATA_BITS   = ((BLOCK_BITS + 7) / 8) * 8;
  localparam int unsigned DIRECTED_CNT = 18;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned HOT_CNT      = 5;
  localparam int unsigned TAIL_CYCLES  = 4 * (WAYS + 1) + 8;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned PRINT_CAP    = 20;

  // One lookup outcome: hit flag, way, fill request.
  typedef struct packed {
    logic                  hit;
    logic [WayOutBits-1:0] way;
    logic                  fill;
  } lookup_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic                  mode;
    logic [BLOCK_BITS-1:0] blk;
    logic                  typed;
    lookup_t               want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_BITS-1:0] s_axis_tdata;   // block_number
  logic                  s_axis_tuser;   // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // way
  logic [1:0]            m_axis_tuser;   // hit (bit 0), fill (bit 1)

  // Shadow copy of the cache state
  logic [BLOCK_BITS-1:0] cache_tags [WAYS];
  logic [AGE_BITS-1:0]   cache_ages [WAYS];
  logic [3:0]            scan_ptr;

  lookup_t               pending_lookups [$];
  lookup_t               oldest_lookup;
  row_t                  directed_rows [DIRECTED_CNT];
  logic [BLOCK_BITS-1:0] hot_blocks [HOT_CNT];

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned reqs_sent;
  int unsigned results_checked;
  int unsigned hits_seen;
  int unsigned fills_seen;
  int unsigned write_misses_seen;
  bit          age_saturated_seen;

  block_cache_age_policy dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Generate the clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Age one way, holding it at the top value
  function automatic void age_way(input int unsigned w);
    if (cache_ages[w] != '1) begin
      cache_ages[w] = cache_ages[w] + 1'b1;
    end else begin
      age_saturated_seen = 1'b1;
    end
  endfunction

  // Predict one request and advance the shadow state
  function automatic lookup_t lookup_block(input logic mode, input logic [BLOCK_BITS-1:0] blk);
    lookup_t     res;
    int unsigned victim;
    int unsigned p;
    int unsigned i;
    bit          done;
    res    = '0;
    victim = 0;
    done   = 1'b0;
    if (mode == ModeRead) begin
      // Rotate through the ways until a hit, tracking the oldest as victim
      for (i = 0; i < WAYS; i++) begin
        if (!done) begin
          p = scan_ptr + 1;
          if (p >= WAYS) p = 0;
          scan_ptr = p[3:0];
          if (cache_tags[p] == blk) begin
            cache_ages[p] = '0;
            res.hit       = 1'b1;
            res.way       = WayOutBits'(p);
            done          = 1'b1;
          end else begin
            age_way(p);
            if (cache_ages[victim] < cache_ages[p]) victim = p;
          end
        end
      end
      if (!done) begin
        cache_tags[victim] = blk;
        cache_ages[victim] = '0;
        res.way            = WayOutBits'(victim);
        res.fill           = 1'b1;
      end
    end else begin
      // Scan from way 0, never allocate
      for (i = 0; i < WAYS; i++) begin
        if (!done) begin
          if (cache_tags[i] == blk) begin
            cache_ages[i] = '0;
            res.hit       = 1'b1;
            res.way       = WayOutBits'(i);
            done          = 1'b1;
          end else begin
            age_way(i);
          end
        end
      end
    end
    return res;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < PRINT_CAP) begin
      $display("ERROR at %0t, result %0d: %s, expected 0x%0h, got 0x%0h",
               $time, results_checked, what, want, got);
    end
    mismatches++;
  endtask

  // Offer one item after a random gap; predict it once accepted
  task automatic send_req(input logic mode, input logic [BLOCK_BITS-1:0] blk,
                          input logic typed, input lookup_t want);
    lookup_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= TDATA_BITS'(blk);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = lookup_block(mode, blk);
    pending_lookups.push_back(typed ? want : got);
    reqs_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every expected result has come
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_lookups.size() != 0);
  endtask

  // Stall the receiver at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with no request pending", 0,
                        32'({m_axis_tuser, m_axis_tdata}));
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (m_axis_tuser[0] !== oldest_lookup.hit)
          report_mismatch("hit", 32'(oldest_lookup.hit), 32'(m_axis_tuser[0]));
        if (m_axis_tdata !== {{(8 - WayOutBits){1'b0}}, oldest_lookup.way})
          report_mismatch("way", 32'(oldest_lookup.way), 32'(m_axis_tdata));
        if (m_axis_tuser[1] !== oldest_lookup.fill)
          report_mismatch("fill", 32'(oldest_lookup.fill), 32'(m_axis_tuser[1]));
        if (oldest_lookup.hit) hits_seen++;
        else if (oldest_lookup.fill) fills_seen++;
        else write_misses_seen++;
      end
      results_checked++;
    end
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_lookups.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned           n;
    int unsigned           phase;
    int unsigned           sel;
    logic [BLOCK_BITS-1:0] blk;
    logic                  mode;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeRead;
    m_axis_tready = 1'b0;
    src_idle_pct  = 10;
    dst_idle_pct  = 62;
    cycle_count   = 0;
    mismatches    = 0;
    reqs_sent     = 0;
    results_checked    = 0;
    hits_seen          = 0;
    fills_seen         = 0;
    write_misses_seen  = 0;
    age_saturated_seen = 1'b0;
    scan_ptr = '0;
    foreach (cache_tags[w]) begin
      cache_tags[w] = '0;
      cache_ages[w] = '0;
    end

    // Directed table: all-zero tags after reset, write hit and miss, extremes,
    // alternating bit patterns and enough reads to wrap the scan pointer
    directed_rows[0]  = {ModeRead,  24'h000000, 1'b1, 1'b1, 4'd1, 1'b0};
    directed_rows[1]  = {ModeWrite, 24'h000000, 1'b1, 1'b1, 4'd0, 1'b0};
    directed_rows[2]  = {ModeWrite, 24'hFFFFFF, 1'b1, 1'b0, 4'd0, 1'b0};
    directed_rows[3]  = {ModeRead,  24'hFFFFFF, 1'b0, 6'd0};
    directed_rows[4]  = {ModeRead,  24'h000001, 1'b0, 6'd0};
    directed_rows[5]  = {ModeRead,  24'h800000, 1'b0, 6'd0};
    directed_rows[6]  = {ModeRead,  24'hFFFFFF, 1'b0, 6'd0};
    directed_rows[7]  = {ModeWrite, 24'h000001, 1'b0, 6'd0};
    directed_rows[8]  = {ModeWrite, 24'h123456, 1'b1, 1'b0, 4'd0, 1'b0};
    directed_rows[9]  = {ModeRead,  24'h555555, 1'b0, 6'd0};
    directed_rows[10] = {ModeRead,  24'hAAAAAA, 1'b0, 6'd0};
    directed_rows[11] = {ModeRead,  24'h555555, 1'b0, 6'd0};
    directed_rows[12] = {ModeWrite, 24'hAAAAAA, 1'b0, 6'd0};
    directed_rows[13] = {ModeRead,  24'h000000, 1'b0, 6'd0};
    directed_rows[14] = {ModeWrite, 24'h000000, 1'b0, 6'd0};
    directed_rows[15] = {ModeRead,  24'h7FFFFF, 1'b0, 6'd0};
    directed_rows[16] = {ModeRead,  24'hFFFFFE, 1'b0, 6'd0};
    directed_rows[17] = {ModeWrite, 24'h7FFFFF, 1'b0, 6'd0};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (n = 0; n < DIRECTED_CNT; n++) begin
      send_req(directed_rows[n].mode, directed_rows[n].blk,
               directed_rows[n].typed, directed_rows[n].want);
    end
    wait_results_done();

    // Random requests, mostly on a small working set so hits and evictions mix
    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 62 : 0;
      dst_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 10 : 0;
      foreach (hot_blocks[h]) hot_blocks[h] = BLOCK_BITS'($urandom);
      for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
        sel = $urandom_range(99);
        if (sel < 65) blk = hot_blocks[$urandom_range(HOT_CNT - 1)];
        else if (sel < 75) blk = cache_tags[$urandom_range(WAYS - 1)];
        else if (sel < 95) blk = BLOCK_BITS'($urandom);
        else blk = ($urandom_range(1) != 0) ? '1 : '0;
        mode = ($urandom_range(99) < 35) ? ModeWrite : ModeRead;
        send_req(mode, blk, 1'b0, '0);
      end
      wait_results_done();
    end

    // Let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_lookups.size() != 0)
      report_mismatch("results never arrived", 0, pending_lookups.size());

    $display("Covered %0d requests, %0d results: %0d hits, %0d read fills, %0d write misses",
             reqs_sent, results_checked, hits_seen, fills_seen, write_misses_seen);
    $display("Ages reached saturation: %0s, mismatches: %0d",
             age_saturated_seen ? "yes" : "no", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
